/* rtl/ppvd_pkg.sv */
`default_nettype none

package ppvd_pkg;

    // configuration port
    localparam int CFG_ADDR_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 32;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_DETECT_MODE = 2'd0,
        CFG_WINDOW_LOW  = 2'd1,
        CFG_WINDOW_HIGH = 2'd2
    } cfg_addr_t;

    // valley window bounds, signed Q16.16
    localparam int WINDOW_WIDTH = 32;
    localparam logic signed [WINDOW_WIDTH-1:0] WINDOW_LOW_RESET  = -32'sd65536;
    localparam logic signed [WINDOW_WIDTH-1:0] WINDOW_HIGH_RESET = 32'sd0;

    typedef enum logic {
        MODE_PEAK   = 1'b0,
        MODE_VALLEY = 1'b1
    } detect_mode_t;

endpackage

`default_nettype wire

/* rtl/plateau_peak_valley_detector.sv */
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: sample; s_tuser: first
// m_        out  m_tvalid/m_tready  m_tdata: peak_index
// cfg_      in   cfg_we             cfg_addr, cfg_wdata (no read-back)
//
// One word per cycle sustained while the m_ side is not stalled: an input register
// and a result register, with the detector compare/add logic between them. m_tvalid
// comes from the result register, loaded when a word that completes a detection leaves the input register.
// A stalled m_ side holds the result register; an empty input register can still
// take one word, then s_tready drops until the result is taken.
// aresetn is synchronous, active low; config returns to peak mode, window [-1,0].
`default_nettype none

module plateau_peak_valley_detector #(
    parameter int INDEX_WIDTH  = 24,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // [SAMPLE_WIDTH-1:0] sample
    input  wire logic                                 s_tuser,  // [0] first

    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((INDEX_WIDTH+7)/8)*8-1:0]          m_tdata,  // [INDEX_WIDTH-1:0] peak_index

    input  wire logic                                 cfg_we,
    input  wire logic [ppvd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  wire logic [ppvd_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    localparam int M_TDATA_WIDTH = ((INDEX_WIDTH + 7) / 8) * 8;
    localparam int CMP_WIDTH = (SAMPLE_WIDTH > ppvd_pkg::WINDOW_WIDTH) ?
                               SAMPLE_WIDTH : ppvd_pkg::WINDOW_WIDTH;
    localparam logic [INDEX_WIDTH-1:0] INDEX_TOP = '1;
    localparam logic [INDEX_WIDTH-1:0] INDEX_TWO = INDEX_WIDTH'(2);
    localparam logic [INDEX_WIDTH-1:0] INDEX_ONE = INDEX_WIDTH'(1);

    // configuration
    ppvd_pkg::detect_mode_t                      mode_reg;
    logic signed [ppvd_pkg::WINDOW_WIDTH-1:0]    win_low_reg;
    logic signed [ppvd_pkg::WINDOW_WIDTH-1:0]    win_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= ppvd_pkg::MODE_PEAK;
            win_low_reg  <= ppvd_pkg::WINDOW_LOW_RESET;
            win_high_reg <= ppvd_pkg::WINDOW_HIGH_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                ppvd_pkg::CFG_DETECT_MODE: mode_reg <= ppvd_pkg::detect_mode_t'(cfg_wdata[0]);
                ppvd_pkg::CFG_WINDOW_LOW:  win_low_reg  <= cfg_wdata;
                ppvd_pkg::CFG_WINDOW_HIGH: win_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    logic                            in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]  in_sample_reg;
    logic                            in_first_reg;
    logic                            advance;

    // result register
    logic                            out_valid_reg;
    logic [INDEX_WIDTH-1:0]          out_index_reg;

    // detector state
    logic signed [SAMPLE_WIDTH-1:0]  older_reg;
    logic signed [SAMPLE_WIDTH-1:0]  newer_reg;
    logic [INDEX_WIDTH-1:0]          count_reg;
    logic [INDEX_WIDTH-1:0]          rise_idx_reg;
    logic                            in_run_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            in_first_reg  <= s_tuser;
        end
    end

    // judge the middle sample (newer_reg) against its neighbors
    logic [INDEX_WIDTH-1:0]          cnt;
    logic [INDEX_WIDTH-1:0]          rise_idx;
    logic                            run;
    logic [INDEX_WIDTH-1:0]          mid_index;
    logic                            valley;
    logic                            falls;
    logic                            rises;
    logic                            turns;
    logic signed [CMP_WIDTH-1:0]     cur_ext;
    logic signed [CMP_WIDTH-1:0]     low_ext;
    logic signed [CMP_WIDTH-1:0]     high_ext;
    logic                            in_window;
    logic [INDEX_WIDTH:0]            mid_sum;
    logic                            emit_next;
    logic [INDEX_WIDTH-1:0]          count_next;
    logic [INDEX_WIDTH-1:0]          rise_idx_next;
    logic                            in_run_next;

    always_comb begin
        cnt       = in_first_reg ? '0 : count_reg;
        rise_idx  = in_first_reg ? '0 : rise_idx_reg;
        run       = in_first_reg ? 1'b0 : in_run_reg;
        mid_index = cnt - INDEX_ONE;

        valley = (mode_reg == ppvd_pkg::MODE_VALLEY);
        falls  = valley ? (newer_reg > older_reg) : (newer_reg < older_reg);
        rises  = valley ? (newer_reg < older_reg) : (newer_reg > older_reg);
        turns  = valley ? (newer_reg < in_sample_reg) : (newer_reg > in_sample_reg);

        cur_ext   = CMP_WIDTH'(newer_reg);
        low_ext   = CMP_WIDTH'(win_low_reg);
        high_ext  = CMP_WIDTH'(win_high_reg);
        in_window = !valley || ((cur_ext >= low_ext) && (cur_ext <= high_ext));

        rise_idx_next = rise_idx;
        in_run_next   = run;
        emit_next     = 1'b0;
        if (cnt >= INDEX_TWO) begin
            if (falls) begin
                in_run_next = 1'b0;
            end
            if (rises) begin
                rise_idx_next = mid_index;
                in_run_next   = 1'b1;
            end
            if (turns && in_run_next) begin
                emit_next   = in_window;
                in_run_next = 1'b0;
            end
        end
        // floor midpoint of run start and turning index
        mid_sum = {1'b0, rise_idx_next} + {1'b0, mid_index};

        count_next = (cnt != INDEX_TOP) ? cnt + INDEX_ONE : cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg    <= '0;
            newer_reg    <= '0;
            count_reg    <= '0;
            rise_idx_reg <= '0;
            in_run_reg   <= 1'b0;
        end else if (advance) begin
            older_reg    <= newer_reg;
            newer_reg    <= in_sample_reg;
            count_reg    <= count_next;
            rise_idx_reg <= rise_idx_next;
            in_run_reg   <= in_run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit_next;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit_next) begin
            out_index_reg <= mid_sum[INDEX_WIDTH:1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_WIDTH'(out_index_reg);

`ifndef SYNTHESIS
    // a run never starts past the samples seen so far
    a_rise_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rise_idx_reg <= count_reg)
        else $error("run start beyond sample count");

    // a fresh result only comes from a word leaving the input register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without input word");

    // index never goes backward within a sequence
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_first_reg) |=> count_reg >= $past(count_reg))
        else $error("sample count went backward");

    // input stalls only when the result side is blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without output backpressure");
`endif

endmodule

`default_nettype wire
